/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sobel edge filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sobel edge filter: next-cycle check failed");

`endif

/* sv/sef_pkg.sv */
// ----------------------------------------------------------------------------
// sef_pkg
// Types, register codes and the Sobel neighbor table of the edge filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

	// Field widths.
	localparam int DIM_W      = 9;
	localparam int LIMIT_W    = 10;
	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int ACC_W      = 12;
	localparam int MAG_W      = 11;
	localparam int STEP_W     = 3;
	localparam int NB_COUNT   = 8;
	localparam int MIN_DIM    = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 2'd3;

	// Input item operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd225;
	localparam int                 DIM_RESET   = 256;

	typedef logic signed [1:0]       offs_t;
	typedef logic signed [2:0]       wgt_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// Neighbor offsets and weights, in fetch order (center pixel is not used).
	localparam offs_t NB_DR [NB_COUNT] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
		2'sd0, 2'sd1, 2'sd1, 2'sd1};
	localparam offs_t NB_DC [NB_COUNT] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
		2'sd1, -2'sd1, 2'sd0, 2'sd1};
	localparam wgt_t  NB_WX [NB_COUNT] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2,
		3'sd2, -3'sd1, 3'sd0, 3'sd1};
	localparam wgt_t  NB_WY [NB_COUNT] = '{3'sd1, 3'sd2, 3'sd1, 3'sd0,
		3'sd0, -3'sd1, -3'sd2, -3'sd1};

	// Pixel times a weight of -2..2, by shift and negate.
	function automatic acc_t weigh(input wgt_t w, input logic [PIX_W-1:0] p);
		acc_t pe;
		acc_t res;
		pe = acc_t'({{(ACC_W-PIX_W){1'b0}}, p});
		case (w)
			3'sd1:   res = pe;
			3'sd2:   res = pe <<< 1;
			-3'sd1:  res = -pe;
			-3'sd2:  res = -(pe <<< 1);
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/sobel_edge_frame_filter_core.sv */
// ----------------------------------------------------------------------------
// sobel_edge_frame_filter_core
// Frame store with a 3x3 Sobel edge filter read out in raster order.
// ----------------------------------------------------------------------------
// A load item writes one pixel into the frame memory and gives no
// result. A read item gives one filtered pixel: the sequencer fetches the
// eight neighbors of the clamped window center one per cycle from the
// single-port frame memory and a shared accumulator folds each into Gx and
// Gy; a drain step, the magnitude step and the decision follow before the
// result is offered. The input is not ready while a read is in progress.
// No clearing pass runs after reset; pixels must be loaded before they are
// read.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sobel_edge_frame_filter_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration writes.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sef_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input items.
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            operation,
	input  wire logic [sef_pkg::PIX_W-1:0]       pixel,
	// Result items.
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [sef_pkg::PIX_W-1:0]            edge_value,
	output logic                                 last_of_frame
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW = RW + CW;
	localparam int EW = ((CW > RW ? CW : RW) > sef_pkg::DIM_W ?
		(CW > RW ? CW : RW) : sef_pkg::DIM_W) + 1;
	localparam logic [sef_pkg::DIM_W-1:0] W_RESET = sef_pkg::DIM_W'(
		(MAX_WIDTH < sef_pkg::DIM_RESET) ? MAX_WIDTH : sef_pkg::DIM_RESET);
	localparam logic [sef_pkg::DIM_W-1:0] H_RESET = sef_pkg::DIM_W'(
		(MAX_HEIGHT < sef_pkg::DIM_RESET) ? MAX_HEIGHT : sef_pkg::DIM_RESET);
	localparam logic [sef_pkg::DIM_W-1:0] DIM_MIN = sef_pkg::DIM_W'(sef_pkg::MIN_DIM);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_MAG   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// Configuration registers.
	logic [sef_pkg::DIM_W-1:0]   width_q, height_q;
	logic [sef_pkg::LIMIT_W-1:0] limit_q;
	logic [sef_pkg::PIX_W-1:0]   fill_q;
	logic [sef_pkg::DIM_W-1:0]   w_clamp, h_clamp;

	// Control and datapath registers.
	logic [2:0]                  state_q;
	logic [CW-1:0]               load_col_q, read_col_q;
	logic [RW-1:0]               load_row_q, read_row_q;
	logic [CW-1:0]               cc_q;
	logic [RW-1:0]               cr_q;
	logic                        last_q;
	logic [sef_pkg::STEP_W-1:0]  step_q;
	logic                        fetch_s1;
	logic [sef_pkg::STEP_W-1:0]  tap_s1;
	logic [sef_pkg::PIX_W-1:0]   rd_data_s1;
	sef_pkg::acc_t               gx_q, gy_q;
	logic [sef_pkg::MAG_W-1:0]   ax_q, ay_q;
	logic                        out_valid_q;
	logic [sef_pkg::PIX_W-1:0]   edge_q;
	logic                        out_last_q;

	logic [sef_pkg::PIX_W-1:0]   mem [2**AW];

	logic                        cfg_fire, in_fire, load_fire, read_fire;
	logic [EW-1:0]               w_ext, h_ext, wm1, hm1, wm2, hm2;
	logic [CW-1:0]               load_col_nx, read_col_nx, cc_nx;
	logic [RW-1:0]               load_row_nx, read_row_nx, cr_nx;
	logic                        last_nx;
	logic [RW-1:0]               nb_row;
	logic [CW-1:0]               nb_col;
	logic [AW-1:0]               mem_addr;
	logic [sef_pkg::MAG_W-1:0]   ax_nx, ay_nx;
	logic [sef_pkg::MAG_W:0]     mag_sum;
	logic [sef_pkg::MAG_W-1:0]   mag_avg;
	logic [sef_pkg::PIX_W-1:0]   result_nx;
	logic                        out_free;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (operation == sef_pkg::OP_LOAD);
	assign read_fire = in_fire && (operation == sef_pkg::OP_READ);
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign edge_value    = edge_q;
	assign last_of_frame = out_last_q;

	// Frame sizes are held to the legal range when written.
	always_comb begin
		if (cfg_data[sef_pkg::DIM_W-1:0] < sef_pkg::DIM_W'(sef_pkg::MIN_DIM)) begin
			w_clamp = sef_pkg::DIM_W'(sef_pkg::MIN_DIM);
		end else if (32'(cfg_data[sef_pkg::DIM_W-1:0]) > MAX_WIDTH) begin
			w_clamp = sef_pkg::DIM_W'(MAX_WIDTH);
		end else begin
			w_clamp = cfg_data[sef_pkg::DIM_W-1:0];
		end
		if (cfg_data[sef_pkg::DIM_W-1:0] < sef_pkg::DIM_W'(sef_pkg::MIN_DIM)) begin
			h_clamp = sef_pkg::DIM_W'(sef_pkg::MIN_DIM);
		end else if (32'(cfg_data[sef_pkg::DIM_W-1:0]) > MAX_HEIGHT) begin
			h_clamp = sef_pkg::DIM_W'(MAX_HEIGHT);
		end else begin
			h_clamp = cfg_data[sef_pkg::DIM_W-1:0];
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RESET;
			height_q <= H_RESET;
			limit_q  <= sef_pkg::LIMIT_RESET;
			fill_q   <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				sef_pkg::CFG_WIDTH:  width_q  <= w_clamp;
				sef_pkg::CFG_HEIGHT: height_q <= h_clamp;
				sef_pkg::CFG_LIMIT:  limit_q  <= cfg_data[sef_pkg::LIMIT_W-1:0];
				sef_pkg::CFG_FILL:   fill_q   <= cfg_data[sef_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Size-derived bounds, widened so stale positions compare correctly.
	assign w_ext = EW'(width_q);
	assign h_ext = EW'(height_q);
	assign wm1   = w_ext - EW'(1);
	assign hm1   = h_ext - EW'(1);
	assign wm2   = w_ext - EW'(2);
	assign hm2   = h_ext - EW'(2);

	// Raster advance of the load and read positions.
	always_comb begin
		load_col_nx = load_col_q;
		load_row_nx = load_row_q;
		if (EW'(load_col_q) >= wm1) begin
			load_col_nx = '0;
			load_row_nx = (EW'(load_row_q) >= hm1) ? '0 : load_row_q + RW'(1);
		end else begin
			load_col_nx = load_col_q + CW'(1);
		end
		read_col_nx = read_col_q;
		read_row_nx = read_row_q;
		if (EW'(read_col_q) >= wm1) begin
			read_col_nx = '0;
			read_row_nx = (EW'(read_row_q) >= hm1) ? '0 : read_row_q + RW'(1);
		end else begin
			read_col_nx = read_col_q + CW'(1);
		end
	end

	// Window center clamped to the interior, and the end-of-frame flag.
	always_comb begin
		if (read_row_q == '0) begin
			cr_nx = RW'(1);
		end else if (EW'(read_row_q) > hm2) begin
			cr_nx = hm2[RW-1:0];
		end else begin
			cr_nx = read_row_q;
		end
		if (read_col_q == '0) begin
			cc_nx = CW'(1);
		end else if (EW'(read_col_q) > wm2) begin
			cc_nx = wm2[CW-1:0];
		end else begin
			cc_nx = read_col_q;
		end
		last_nx = (EW'(read_row_q) >= hm1) && (EW'(read_col_q) >= wm1);
	end

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q <= '0;
			load_col_q <= '0;
			read_row_q <= '0;
			read_col_q <= '0;
		end else begin
			if (load_fire) begin
				load_row_q <= load_row_nx;
				load_col_q <= load_col_nx;
			end
			if (read_fire) begin
				read_row_q <= read_row_nx;
				read_col_q <= read_col_nx;
			end
		end
	end

	// Neighbor address for the current fetch step.
	assign nb_row   = cr_q + RW'(sef_pkg::NB_DR[step_q]);
	assign nb_col   = cc_q + CW'(sef_pkg::NB_DC[step_q]);
	assign mem_addr = load_fire ? {load_row_q, load_col_q} : {nb_row, nb_col};

	// Single-port frame memory with registered read data.
	always_ff @(posedge clk) begin
		if (load_fire) begin
			mem[mem_addr] <= pixel;
		end else begin
			rd_data_s1 <= mem[mem_addr];
		end
	end

	// Sequencer over the eight neighbor fetches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			fetch_s1 <= 1'b0;
			tap_s1   <= '0;
		end else begin
			fetch_s1 <= (state_q == ST_FETCH);
			tap_s1   <= step_q;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (read_fire) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					step_q <= step_q + sef_pkg::STEP_W'(1);
					if (step_q == sef_pkg::STEP_W'(sef_pkg::NB_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_MAG;
				ST_MAG:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window center and flag, captured when a read is accepted.
	always_ff @(posedge clk) begin
		if (read_fire) begin
			cr_q   <= cr_nx;
			cc_q   <= cc_nx;
			last_q <= last_nx;
		end
	end

	// Shared accumulator: one weighted neighbor per cycle into Gx and Gy.
	always_ff @(posedge clk) begin
		if (read_fire) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (fetch_s1) begin
			gx_q <= gx_q + sef_pkg::weigh(sef_pkg::NB_WX[tap_s1], rd_data_s1);
			gy_q <= gy_q + sef_pkg::weigh(sef_pkg::NB_WY[tap_s1], rd_data_s1);
		end
	end

	// Gradient magnitudes.
	assign ax_nx = gx_q[sef_pkg::ACC_W-1] ? sef_pkg::MAG_W'(-gx_q) : sef_pkg::MAG_W'(gx_q);
	assign ay_nx = gy_q[sef_pkg::ACC_W-1] ? sef_pkg::MAG_W'(-gy_q) : sef_pkg::MAG_W'(gy_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_MAG) begin
			ax_q <= ax_nx;
			ay_q <= ay_nx;
		end
	end

	// Limit test, average and saturation.
	always_comb begin
		mag_sum = {1'b0, ax_q} + {1'b0, ay_q};
		mag_avg = mag_sum[sef_pkg::MAG_W:1];
		if ((ax_q < sef_pkg::MAG_W'(limit_q)) && (ay_q < sef_pkg::MAG_W'(limit_q))) begin
			result_nx = (mag_avg > sef_pkg::MAG_W'(255)) ? 8'hFF : mag_avg[sef_pkg::PIX_W-1:0];
		end else begin
			result_nx = fill_q;
		end
	end

	// Output register; loads may continue while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			edge_q     <= result_nx;
			out_last_q <= last_q;
		end
	end

	// Checks on the sequencer and configuration.
	`SEF_ASSERT_NEXT(a_read_starts_fetch, read_fire, state_q == ST_FETCH && step_q == '0)
	`SEF_ASSERT_SAME(a_fetch_in_window, fetch_s1, state_q == ST_FETCH || state_q == ST_DRAIN)
	`SEF_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && !out_free, state_q == ST_DONE)
	`SEF_ASSERT_SAME(a_size_legal, 1'b1, width_q >= DIM_MIN && height_q >= DIM_MIN)

endmodule

`default_nettype wire

/* verif/sobel_edge_frame_filter_core_test.sv */
// ----------------------------------------------------------------------------
// sobel_edge_frame_filter_core_test
// Loads grey frames of many sizes, reads the filtered pixels back in raster
// order and compares every result with a predictor kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_frame_filter_core_test;

	localparam int   FRAME_MAX     = 256;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   LOG_LIMIT     = 100;

	typedef enum int {TEX_NOISE, TEX_RAMP, TEX_BINARY, TEX_CHECKER} texture_t;
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LIGHT, STALL_HEAVY} stall_t;

	typedef struct packed {
		logic [sef_pkg::PIX_W-1:0] edge_value;
		logic                      last_of_frame;
	} edge_result_t;

	// Block ports; every input starts at a known value.
	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [sef_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [sef_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
	logic                           in_valid      = 1'b0;
	logic                           in_ready;
	logic                           operation     = 1'b0;
	logic [sef_pkg::PIX_W-1:0]      pixel         = '0;
	logic                           out_valid;
	logic                           out_ready     = 1'b0;
	logic [sef_pkg::PIX_W-1:0]      edge_value;
	logic                           last_of_frame;

	// Predictor copy of the frame memory, counters and registers.
	bit [sef_pkg::PIX_W-1:0] frame_copy [FRAME_MAX*FRAME_MAX];
	bit                      pixel_loaded [FRAME_MAX*FRAME_MAX];
	int                      frame_w    = sef_pkg::DIM_RESET;
	int                      frame_h    = sef_pkg::DIM_RESET;
	int                      grad_limit = int'(sef_pkg::LIMIT_RESET);
	int                      fill_pixel = 0;
	int                      load_r     = 0;
	int                      load_c     = 0;
	int                      read_r     = 0;
	int                      read_c     = 0;

	edge_result_t   expected_edges [$];
	int             error_count         = 0;
	int             burst_left          = 0;
	int             result_hold_request = 0;

	sobel_edge_frame_filter_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.edge_value    (edge_value),
		.last_of_frame (last_of_frame)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int fit_dimension(int v);
		if (v < sef_pkg::MIN_DIM)
			return sef_pkg::MIN_DIM;
		if (v > FRAME_MAX)
			return FRAME_MAX;
		return v;
	endfunction

	function automatic int store_slot(int r, int c);
		return (r % FRAME_MAX) * FRAME_MAX + (c % FRAME_MAX);
	endfunction

	function automatic int stored_pixel(int r, int c);
		return int'(frame_copy[store_slot(r, c)]);
	endfunction

	// Window centers stay inside the frame so the borders are replicated.
	function automatic int window_center(int v, int size);
		if (v < 1)
			return 1;
		if (v > size - 2)
			return size - 2;
		return v;
	endfunction

	// Raster advance; a counter beyond a shrunk frame wraps at its next step.
	function automatic void step_position(inout int r, inout int c);
		c++;
		if (c >= frame_w) begin
			c = 0;
			r++;
			if (r >= frame_h)
				r = 0;
		end
	endfunction

	// A read is only issued when its whole window holds loaded pixels.
	function automatic bit read_window_loaded();
		int cr;
		int cc;
		cr = window_center(read_r, frame_h);
		cc = window_center(read_c, frame_w);
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (!pixel_loaded[store_slot(cr + dr, cc + dc)])
					return 1'b0;
		return 1'b1;
	endfunction

	// Sobel magnitudes at the clamped center, then average or fill.
	function automatic edge_result_t predict_edge_pixel();
		int cr;
		int cc;
		int gx;
		int gy;
		int ax;
		int ay;
		int avg;
		edge_result_t res;
		cr = window_center(read_r, frame_h);
		cc = window_center(read_c, frame_w);
		gx = stored_pixel(cr - 1, cc + 1) + 2 * stored_pixel(cr, cc + 1)
			+ stored_pixel(cr + 1, cc + 1) - stored_pixel(cr - 1, cc - 1)
			- 2 * stored_pixel(cr, cc - 1) - stored_pixel(cr + 1, cc - 1);
		gy = stored_pixel(cr - 1, cc - 1) + 2 * stored_pixel(cr - 1, cc)
			+ stored_pixel(cr - 1, cc + 1) - stored_pixel(cr + 1, cc - 1)
			- 2 * stored_pixel(cr + 1, cc) - stored_pixel(cr + 1, cc + 1);
		ax = (gx < 0) ? -gx : gx;
		ay = (gy < 0) ? -gy : gy;
		if (ax < grad_limit && ay < grad_limit) begin
			avg = (ax + ay) / 2;
			res.edge_value = (avg > 255) ? 8'hFF : 8'(avg);
		end else begin
			res.edge_value = 8'(fill_pixel);
		end
		res.last_of_frame = (read_r >= frame_h - 1 && read_c >= frame_w - 1);
		return res;
	endfunction

	// Update the predictor with one accepted item.
	function automatic void apply_item(logic op, logic [sef_pkg::PIX_W-1:0] pix);
		int slot;
		if (op == sef_pkg::OP_LOAD) begin
			slot = store_slot(load_r, load_c);
			frame_copy[slot] = pix;
			pixel_loaded[slot] = 1'b1;
			step_position(load_r, load_c);
		end else begin
			expected_edges.push_back(predict_edge_pixel());
			step_position(read_r, read_c);
		end
	endfunction

	// Update the predictor with one register write.
	function automatic void apply_register(logic [sef_pkg::CFG_IDX_W-1:0] idx,
			logic [sef_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			sef_pkg::CFG_WIDTH:  frame_w = fit_dimension(int'(data[sef_pkg::DIM_W-1:0]));
			sef_pkg::CFG_HEIGHT: frame_h = fit_dimension(int'(data[sef_pkg::DIM_W-1:0]));
			sef_pkg::CFG_LIMIT:  grad_limit = int'(data);
			sef_pkg::CFG_FILL:   fill_pixel = int'(data[sef_pkg::PIX_W-1:0]);
			default: ;
		endcase
	endfunction

	// Pixel content for the next load, by the texture chosen for the phase.
	function automatic logic [sef_pkg::PIX_W-1:0] texture_pixel(texture_t tex);
		case (tex)
			TEX_RAMP:    return 8'(load_r * 5 + load_c * 3 + int'($urandom_range(0, 7)));
			TEX_BINARY:  return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			TEX_CHECKER: return (((load_r / 2) + (load_c / 2)) % 2 != 0) ? 8'd200 : 8'd30;
			default:     return 8'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= LOG_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Offer one item, hold it until accepted, then maybe leave a gap.
	task automatic offer_item(input logic op, input logic [sef_pkg::PIX_W-1:0] pix);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		pixel <= pix;
		do @(posedge clk); while (!in_ready);
		apply_item(op, pix);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Random mix of loads and reads; a read whose window is not loaded yet
	// turns into a load, so reads trail the loads through the frame.
	task automatic run_mixed(input int count, input int read_pct, input texture_t tex);
		logic                      op;
		logic [sef_pkg::PIX_W-1:0] pix;
		repeat (count) begin
			op = (int'($urandom_range(0, 99)) < read_pct) ? sef_pkg::OP_READ : sef_pkg::OP_LOAD;
			if (op == sef_pkg::OP_READ && !read_window_loaded())
				op = sef_pkg::OP_LOAD;
			pix = (op == sef_pkg::OP_LOAD) ? texture_pixel(tex) : 8'($urandom);
			offer_item(op, pix);
		end
	endtask

	task automatic write_register(input logic [sef_pkg::CFG_IDX_W-1:0] idx,
			input logic [sef_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
	endtask

	task automatic close_register_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [sef_pkg::CFG_DATA_W-1:0] width_data,
			input logic [sef_pkg::CFG_DATA_W-1:0] height_data,
			input logic [sef_pkg::CFG_DATA_W-1:0] limit_data,
			input logic [sef_pkg::CFG_DATA_W-1:0] fill_data);
		write_register(sef_pkg::CFG_WIDTH, width_data);
		write_register(sef_pkg::CFG_HEIGHT, height_data);
		write_register(sef_pkg::CFG_LIMIT, limit_data);
		write_register(sef_pkg::CFG_FILL, fill_data);
		close_register_writes();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_edges.size() != 0)
			@(posedge clk);
	endtask

	// Idle point: no result owed and any load in flight has finished.
	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Smallest frame with a saturating window, a zero limit and odd sizes.
	task automatic test_corner_frame();
		logic [sef_pkg::PIX_W-1:0] corner_pixels [9] = '{8'd0, 8'd255, 8'd255, 8'd0,
			8'd128, 8'd255, 8'd0, 8'd0, 8'd0};
		configure(10'd3, 10'd3, 10'h3FF, 10'h2A5);
		foreach (corner_pixels[i])
			offer_item(sef_pkg::OP_LOAD, corner_pixels[i]);
		repeat (9) offer_item(sef_pkg::OP_READ, 8'($urandom));
		// A zero limit rejects every pixel.
		settle_block();
		write_register(sef_pkg::CFG_LIMIT, 10'd0);
		close_register_writes();
		repeat (2) offer_item(sef_pkg::OP_READ, 8'($urandom));
		// Sizes outside the legal range are pulled back to it.
		settle_block();
		write_register(sef_pkg::CFG_WIDTH, 10'd1);
		write_register(sef_pkg::CFG_HEIGHT, 10'h3FF);
		write_register(sef_pkg::CFG_LIMIT, 10'h3FF);
		close_register_writes();
		repeat (4) offer_item(sef_pkg::OP_READ, 8'($urandom));
	endtask

	// Small frames with random sizes, limits, fill values and textures.
	task automatic test_random_frames();
		int                             w;
		int                             h;
		logic [sef_pkg::CFG_DATA_W-1:0] lim;
		repeat (3) begin
			settle_block();
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
			h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
			case ($urandom_range(0, 5))
				0:       lim = 10'd0;
				1:       lim = 10'h3FF;
				2:       lim = 10'd1020;
				3:       lim = 10'($urandom);
				default: lim = 10'($urandom_range(40, 300));
			endcase
			configure({1'($urandom), 9'(w)}, {1'($urandom), 9'(h)}, lim, 10'($urandom));
			run_mixed($urandom_range(20, 35), $urandom_range(30, 65),
				texture_t'($urandom_range(0, 3)));
		end
	endtask

	// Shrinking the frame leaves the read and load counters beyond it.
	task automatic test_stale_positions();
		settle_block();
		configure(10'd9, 10'd8, 10'd300, 10'h37F);
		run_mixed(70, 45, TEX_CHECKER);
		settle_block();
		configure(10'd3, 10'd4, 10'd1020, 10'h3FF);
		run_mixed(30, 60, TEX_NOISE);
	endtask

	// Widest frame: the right border clamp sits at the last column pair.
	task automatic test_wide_frame();
		settle_block();
		configure(10'h100, 10'd3, 10'd600, 10'd0);
		run_mixed(1100, 55, TEX_RAMP);
	endtask

	// Tallest frame, binary content so most averages saturate.
	task automatic test_tall_frame();
		settle_block();
		configure(10'd3, 10'h100, 10'h3FF, 10'h0FF);
		run_mixed(40, 50, TEX_BINARY);
	endtask

	// Results held off long enough that the block stalls its input, then
	// the sender waits for every owed result before going on.
	task automatic test_result_backpressure();
		settle_block();
		configure(10'd6, 10'd5, 10'd200, 10'd0);
		run_mixed(30, 15, TEX_RAMP);
		result_hold_request = 300;
		run_mixed(25, 90, TEX_NOISE);
		drain_results();
		run_mixed(20, 60, TEX_RAMP);
	endtask

	// Result side: ready follows a rotating pattern, or a long hold-off.
	initial begin : result_sink
		int                hold_left;
		int                pattern_left;
		logic [31:0]       ready_pattern;
		stall_t            mode;
		hold_left = 0;
		pattern_left = 0;
		ready_pattern = '1;
		forever begin
			@(posedge clk);
			if (result_hold_request > 0) begin
				hold_left = result_hold_request;
				result_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					mode = stall_t'($urandom_range(0, 3));
					case (mode)
						STALL_NONE:   ready_pattern = '1;
						STALL_RANDOM: ready_pattern = $urandom | 32'h1;
						STALL_LIGHT:  ready_pattern = $urandom | $urandom;
						default:      ready_pattern = ($urandom & $urandom) | 32'h1;
					endcase
					pattern_left = 64;
				end
				out_ready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
				pattern_left--;
			end
		end
	end

	// Each accepted result is compared with the oldest owed one.
	always @(posedge clk) begin : result_check
		edge_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_edges.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing owed", edge_value));
			end else begin
				want = expected_edges.pop_front();
				if (edge_value !== want.edge_value)
					report_mismatch($sformatf("edge_value %0d, predicted %0d",
						edge_value, want.edge_value));
				if (last_of_frame !== want.last_of_frame)
					report_mismatch($sformatf("last_of_frame %0b, predicted %0b",
						last_of_frame, want.last_of_frame));
			end
		end
	end

	// Test sequence.
	initial begin : test_sequence
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_frame();
		test_random_frames();
		test_stale_positions();
		test_wide_frame();
		test_tall_frame();
		test_result_backpressure();
		settle_block();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/sef_pkg.sv
sv/sobel_edge_frame_filter_core.sv
verif/sobel_edge_frame_filter_core_test.sv
